// File: hw/rtl/bps_pkg.sv
// shared types, widths, constants and the arctangent table for the pitch solver
package bps_pkg;

   // search and cordic sizing
   localparam int MAX_SEARCH_STEPS  = 4096;
   localparam int CORDIC_ITERATIONS = 18;
   localparam int STEP_CNT_W        = $clog2(MAX_SEARCH_STEPS + 1);
   localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

   // channel field widths
   localparam int SIGHT_W    = 18;
   localparam int DIST_W     = 21;
   localparam int SPEED_W    = 21;
   localparam int DEG_W      = 25;
   localparam int STATUS_W   = 2;
   localparam int RADIUS_W   = 16;
   localparam int GRAV_W     = 20;
   localparam int TOL_W      = 16;
   localparam int LIMIT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // internal datapath widths
   localparam int ANG_W   = 26;
   localparam int TRIG_W  = 19;
   localparam int Z_W     = 40;
   localparam int XY_W    = 34;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int H_W     = 25;
   localparam int V_W     = 23;
   localparam int T_W     = 26;
   localparam int ERR_W   = 40;
   localparam int DIVN_W  = 40;
   localparam int DIVD_W  = 23;
   localparam int DCNT_W  = $clog2(DIVN_W + 1);
   localparam int DIVSR_W = 16;
   localparam int STEP_W  = 11;

   // fixed point constants
   localparam logic signed [ANG_W-1:0] PI_Q16       = 26'sd205887;
   localparam logic [DIVN_W-1:0]       DEG1_X256    = 40'd292864;
   localparam logic signed [MUL_W-1:0] RAD2DEG_Q16  = 34'sd3754936;
   localparam logic [DIVSR_W-1:0]      DIV_START    = 16'd205;
   localparam logic [DIVSR_W-1:0]      DIV_INC      = 16'd256;
   localparam logic [DIVN_W-1:0]       T_MAX        = 40'd16777215;
   localparam logic signed [PROD_W-1:0] DEG_MAX     = 68'sd11796480;
   localparam logic signed [PROD_W-1:0] DEG_ROUND   = 68'sd32768;
   localparam logic signed [XY_W-1:0]  CORDIC_K_Q30 = 34'sd652032874;
   localparam logic signed [XY_W-1:0]  TRIG_ROUND   = 34'sd8192;
   localparam logic signed [Z_W-1:0]   PI_Q30       = 40'sd3373259426;
   localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 40'sd1686629713;
   localparam logic signed [Z_W-1:0]   TWO_PI_Q30   = 40'sd6746518852;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERRUN   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_GEOMETRY  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LAUNCHER_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY_ACCEL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_TOLERANCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRECISION_LIMIT  = 2'd3;

   // register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd7733;
   localparam logic [GRAV_W-1:0]   GRAV_RESET   = 20'd641159;
   localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd655;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 6'd20;

   // cordic request and response
   typedef struct packed {
      logic                    start;
      logic signed [ANG_W-1:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] sin;
      logic signed [TRIG_W-1:0] cos;
   } cordic_rsp_type;

   // arctangent of 2^-i in Q30 radians
   function automatic logic signed [XY_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [XY_W-1:0] val;
      unique case (idx)
         5'd0:  val = 34'sd843314857;
         5'd1:  val = 34'sd497837829;
         5'd2:  val = 34'sd263043837;
         5'd3:  val = 34'sd133525159;
         5'd4:  val = 34'sd67021687;
         5'd5:  val = 34'sd33543516;
         5'd6:  val = 34'sd16775851;
         5'd7:  val = 34'sd8388437;
         5'd8:  val = 34'sd4194283;
         5'd9:  val = 34'sd2097149;
         5'd10: val = 34'sd1048575;
         5'd11: val = 34'sd524288;
         5'd12: val = 34'sd262144;
         5'd13: val = 34'sd131072;
         5'd14: val = 34'sd65536;
         5'd15: val = 34'sd32768;
         5'd16: val = 34'sd16384;
         5'd17: val = 34'sd8192;
         5'd18: val = 34'sd4096;
         5'd19: val = 34'sd2048;
         5'd20: val = 34'sd1024;
         5'd21: val = 34'sd512;
         5'd22: val = 34'sd256;
         5'd23: val = 34'sd128;
         5'd24: val = 34'sd64;
         5'd25: val = 34'sd32;
         5'd26: val = 34'sd16;
         5'd27: val = 34'sd8;
         5'd28: val = 34'sd4;
         5'd29: val = 34'sd2;
         default: val = 34'sd0;
      endcase
      return val;
   endfunction

endpackage

// File: hw/rtl/bps_if.sv
// handshake channel interfaces for requests, results and register writes
interface bps_req_if;
   logic                          valid;
   logic                          ready;
   logic [bps_pkg::SIGHT_W-1:0]   sight_angle;
   logic [bps_pkg::DIST_W-1:0]    target_distance;
   logic [bps_pkg::SPEED_W-1:0]   muzzle_speed;
   modport source(output valid, sight_angle, target_distance, muzzle_speed, input ready);
   modport sink(input valid, sight_angle, target_distance, muzzle_speed, output ready);
endinterface

interface bps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bps_pkg::DEG_W-1:0]    compensation_deg;
   logic [bps_pkg::STATUS_W-1:0]        solve_status;
   modport source(output valid, compensation_deg, solve_status, input ready);
   modport sink(input valid, compensation_deg, solve_status, output ready);
endinterface

interface bps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bps_pkg::CSR_IDX_W-1:0]     index;
   logic [bps_pkg::CSR_DATA_W-1:0]    wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/bps_cordic.sv
// iterative cordic unit giving sine and cosine of a Q16 angle
module bps_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  bps_pkg::cordic_req_type creq,
   output bps_pkg::cordic_rsp_type crsp
);

   typedef enum logic [4:0] {
      C_IDLE = 5'b00001,
      C_RED  = 5'b00010,
      C_FOLD = 5'b00100,
      C_ITER = 5'b01000,
      C_DONE = 5'b10000
   } cstate_type;

   cstate_type                        state_ff, state_in;
   logic signed [bps_pkg::Z_W-1:0]    z_ff, z_in;
   logic signed [bps_pkg::XY_W-1:0]   x_ff, x_in;
   logic signed [bps_pkg::XY_W-1:0]   y_ff, y_in;
   logic                              neg_ff, neg_in;
   logic [bps_pkg::ITER_W-1:0]        iter_ff, iter_in;

   logic signed [bps_pkg::Z_W-1:0]    z_wrap;
   logic signed [bps_pkg::XY_W-1:0]   x_sh, y_sh, atan_val;
   logic signed [bps_pkg::XY_W-1:0]   y_rnd, x_rnd;
   logic signed [bps_pkg::TRIG_W-1:0] cos_raw;

   // wrap into -pi..pi
   always_comb begin
      priority if (z_ff > bps_pkg::PI_Q30) begin
         z_wrap = z_ff - bps_pkg::TWO_PI_Q30;
      end else if (z_ff < -bps_pkg::PI_Q30) begin
         z_wrap = z_ff + bps_pkg::TWO_PI_Q30;
      end else begin
         z_wrap = z_ff;
      end
   end

   // one micro-rotation
   assign x_sh     = x_ff >>> iter_ff;
   assign y_sh     = y_ff >>> iter_ff;
   assign atan_val = bps_pkg::atan_q30(5'(iter_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (creq.start) begin
               z_in     = bps_pkg::Z_W'(creq.angle) <<< 14;
               state_in = C_RED;
            end
         end
         C_RED: begin
            // truncating remainder by two pi, one subtraction per cycle
            priority if (z_ff >= bps_pkg::TWO_PI_Q30) begin
               z_in = z_ff - bps_pkg::TWO_PI_Q30;
            end else if (z_ff <= -bps_pkg::TWO_PI_Q30) begin
               z_in = z_ff + bps_pkg::TWO_PI_Q30;
            end else begin
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            // fold into -pi/2..pi/2, cosine sign flips
            priority if (z_wrap > bps_pkg::HALF_PI_Q30) begin
               z_in   = bps_pkg::PI_Q30 - z_wrap;
               neg_in = 1'b1;
            end else if (z_wrap < -bps_pkg::HALF_PI_Q30) begin
               z_in   = -bps_pkg::PI_Q30 - z_wrap;
               neg_in = 1'b1;
            end else begin
               z_in   = z_wrap;
               neg_in = 1'b0;
            end
            x_in     = bps_pkg::CORDIC_K_Q30;
            y_in     = '0;
            iter_in  = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - bps_pkg::Z_W'(atan_val);
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + bps_pkg::Z_W'(atan_val);
            end
            if (iter_ff == bps_pkg::ITER_W'(bps_pkg::CORDIC_ITERATIONS - 1)) begin
               state_in = C_DONE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
   end

   // round back to Q16
   assign y_rnd   = (y_ff + bps_pkg::TRIG_ROUND) >>> 14;
   assign x_rnd   = (x_ff + bps_pkg::TRIG_ROUND) >>> 14;
   assign cos_raw = bps_pkg::TRIG_W'(x_rnd);

   assign crsp.done = (state_ff == C_DONE);
   assign crsp.sin  = bps_pkg::TRIG_W'(y_rnd);
   assign crsp.cos  = neg_ff ? -cos_raw : cos_raw;

endmodule

// File: hw/rtl/ballistic_pitch_solver_top.sv
// pitch solver top level: request sequencer, shared multiplier and divider
//
// Usage: a request item on req_chan carries sight angle, target distance and
// muzzle speed. The solver searches the upward compensation angle and returns
// one result item on rsp_chan with compensation_deg and solve_status.
// Registers (launcher radius, gravity, tolerance, precision limit) are written
// on csr_chan, always ready. The user must write them only while no request
// is in flight; the block itself does not enforce it. req_chan.ready is high
// only while the sequencer is idle; one request is worked at a time. A request
// runs setup, then up to 4096 search steps, each with extra angle-reduction
// turns as needed, then rounds and loads the result. Each step runs two passes
// of the shared restoring divider (step size and flight time), one cordic run
// (reduction, fold, 18 rotations, done) and the multiply, error and compare
// states on the shared 34x34 multiplier.
// The result waits in an output register; a new request may be accepted
// while it waits, and a finished search holds until the register is free.
// Reset returns the sequencer to idle, drops rsp valid and restores the
// register defaults.
module ballistic_pitch_solver_top (
   input  logic clock,
   input  logic reset,
   bps_req_if.sink   req_chan,
   bps_rsp_if.source rsp_chan,
   bps_csr_if.sink   csr_chan
);

   typedef enum logic [18:0] {
      S_IDLE = 19'h00001,
      S_CS0  = 19'h00002,
      S_H1   = 19'h00004,
      S_HZ   = 19'h00008,
      S_HR   = 19'h00010,
      S_HS   = 19'h00020,
      S_STEP = 19'h00040,
      S_SDIV = 19'h00080,
      S_CF   = 19'h00100,
      S_VX   = 19'h00200,
      S_VY   = 19'h00400,
      S_TDIV = 19'h00800,
      S_T1   = 19'h01000,
      S_T2   = 19'h02000,
      S_T3   = 19'h04000,
      S_ERR  = 19'h08000,
      S_EVAL = 19'h10000,
      S_DEG  = 19'h20000,
      S_RND  = 19'h40000
   } state_type;

   // configuration registers
   logic [bps_pkg::RADIUS_W-1:0] radius_ff;
   logic [bps_pkg::GRAV_W-1:0]   grav_ff;
   logic [bps_pkg::TOL_W-1:0]    tol_ff;
   logic [bps_pkg::LIMIT_W-1:0]  limit_ff;

   state_type state_ff, state_in;

   // request operands
   logic [bps_pkg::SIGHT_W-1:0] ap_ff;
   logic [bps_pkg::DIST_W-1:0]  dist_ff;
   logic [bps_pkg::SPEED_W-1:0] spd_ff;

   // search datapath
   logic signed [bps_pkg::TRIG_W-1:0] sp_ff, cp_ff, cf_ff;
   logic signed [bps_pkg::H_W-1:0]    h1_ff, horiz_ff, hr_ff, hh_ff;
   logic signed [bps_pkg::ANG_W-1:0]  comp_ff, comp_in, af_ff;
   logic signed [bps_pkg::V_W-1:0]    vx_ff, vy_ff;
   logic signed [bps_pkg::T_W-1:0]    t_ff, t_in;
   logic signed [bps_pkg::ERR_W-1:0]  vyt_ff, err_ff, err_in, prev_ff;
   logic [bps_pkg::DIVSR_W-1:0]       div_ff;
   logic                              dir_ff;
   logic [bps_pkg::STEP_CNT_W-1:0]    cnt_ff;
   logic [bps_pkg::STATUS_W-1:0]      status_ff;

   // shared multiplier
   logic signed [bps_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [bps_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                              mul_en;

   // shared restoring divider
   logic [bps_pkg::DIVN_W-1:0]  dq_ff, dq_in;
   logic [bps_pkg::DIVD_W-1:0]  drem_ff, drem_in;
   logic [bps_pkg::DIVD_W-1:0]  dden_ff, dden_in;
   logic [bps_pkg::DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic                        div_start, div_done;
   logic [bps_pkg::DIVN_W-1:0]  div_num;
   logic [bps_pkg::DIVD_W-1:0]  div_den;
   logic [bps_pkg::DIVD_W:0]    rem_sh;
   logic                        rem_ge;

   // result register
   logic                               rsp_valid_ff;
   logic signed [bps_pkg::DEG_W-1:0]   rsp_deg_ff;
   logic [bps_pkg::STATUS_W-1:0]       rsp_status_ff;

   // cordic
   bps_pkg::cordic_req_type creq;
   bps_pkg::cordic_rsp_type crsp;

   // step evaluation terms
   logic [bps_pkg::H_W-1:0]          horiz_mag;
   logic [bps_pkg::V_W-1:0]          vx_mag;
   logic [bps_pkg::ERR_W-1:0]        err_mag, prev_mag;
   logic [bps_pkg::DIVSR_W-1:0]      div_inc;
   logic [bps_pkg::STEP_CNT_W-1:0]   cnt_inc;
   logic [bps_pkg::DIVN_W-1:0]       t_mag;
   logic                             reverse, overrun, geom_bad, t_neg;
   logic signed [bps_pkg::ANG_W-1:0] step_val;
   logic signed [bps_pkg::PROD_W-1:0] deg_full;
   logic signed [bps_pkg::DEG_W-1:0] deg_sat;
   logic                             out_free;

   bps_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .creq  (creq),
      .crsp  (crsp)
   );

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bps_pkg::RADIUS_RESET;
         grav_ff   <= bps_pkg::GRAV_RESET;
         tol_ff    <= bps_pkg::TOL_RESET;
         limit_ff  <= bps_pkg::LIMIT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bps_pkg::REG_LAUNCHER_RADIUS:  radius_ff <= bps_pkg::RADIUS_W'(csr_chan.wdata);
            bps_pkg::REG_GRAVITY_ACCEL:    grav_ff   <= csr_chan.wdata;
            bps_pkg::REG_HEIGHT_TOLERANCE: tol_ff    <= bps_pkg::TOL_W'(csr_chan.wdata);
            bps_pkg::REG_PRECISION_LIMIT:  limit_ff  <= bps_pkg::LIMIT_W'(csr_chan.wdata);
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (state_ff)
         S_H1: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, dist_ff}));
            mul_b = bps_pkg::MUL_W'(cp_ff);
         end
         S_HZ: begin
            mul_a = bps_pkg::MUL_W'(sp_ff);
            mul_b = bps_pkg::MUL_W'($signed({1'b0, dist_ff}));
         end
         S_HR: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, radius_ff}));
            mul_b = bps_pkg::MUL_W'(cp_ff);
         end
         S_CF: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, spd_ff}));
            mul_b = bps_pkg::MUL_W'(crsp.sin);
         end
         S_VX: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, spd_ff}));
            mul_b = bps_pkg::MUL_W'(cf_ff);
         end
         S_VY: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, radius_ff}));
            mul_b = bps_pkg::MUL_W'(cf_ff);
         end
         S_T1: begin
            mul_a = bps_pkg::MUL_W'(vy_ff);
            mul_b = bps_pkg::MUL_W'(t_ff);
         end
         S_T2: begin
            mul_a = bps_pkg::MUL_W'(t_ff);
            mul_b = bps_pkg::MUL_W'(t_ff);
         end
         S_T3: begin
            mul_a = bps_pkg::MUL_W'($signed({1'b0, grav_ff}));
            mul_b = bps_pkg::MUL_W'(prod_ff >>> 16);
         end
         S_DEG: begin
            mul_a = bps_pkg::MUL_W'(comp_ff);
            mul_b = bps_pkg::RAD2DEG_Q16;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // divider: one quotient bit per cycle
   assign rem_sh   = {drem_ff, dq_ff[bps_pkg::DIVN_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, dden_ff});
   assign div_done = (dcnt_ff == '0);

   always_comb begin
      dq_in   = dq_ff;
      drem_in = drem_ff;
      dden_in = dden_ff;
      dcnt_in = dcnt_ff;
      if (div_start) begin
         dq_in   = div_num;
         drem_in = '0;
         dden_in = div_den;
         dcnt_in = bps_pkg::DCNT_W'(bps_pkg::DIVN_W);
      end else if (!div_done) begin
         drem_in = rem_ge ? bps_pkg::DIVD_W'(rem_sh - {1'b0, dden_ff})
                          : bps_pkg::DIVD_W'(rem_sh);
         dq_in   = {dq_ff[bps_pkg::DIVN_W-2:0], rem_ge};
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   // magnitudes and per-step terms
   assign horiz_mag = horiz_ff[bps_pkg::H_W-1] ? bps_pkg::H_W'(-horiz_ff)
                                               : bps_pkg::H_W'(horiz_ff);
   assign vx_mag    = vx_ff[bps_pkg::V_W-1] ? bps_pkg::V_W'(-vx_ff) : bps_pkg::V_W'(vx_ff);
   assign err_mag   = err_ff[bps_pkg::ERR_W-1] ? bps_pkg::ERR_W'(-err_ff)
                                               : bps_pkg::ERR_W'(err_ff);
   assign prev_mag  = prev_ff[bps_pkg::ERR_W-1] ? bps_pkg::ERR_W'(-prev_ff)
                                                : bps_pkg::ERR_W'(prev_ff);
   assign div_inc   = div_ff + bps_pkg::DIV_INC;
   assign cnt_inc   = cnt_ff + 1'b1;
   assign reverse   = (prev_ff != '0) && (err_mag > prev_mag);
   assign overrun   = reverse &&
                      (div_inc > bps_pkg::DIVSR_W'({limit_ff, 8'b0}));
   assign geom_bad  = horiz_ff[bps_pkg::H_W-1] || vx_ff[bps_pkg::V_W-1] ||
                      (af_ff > bps_pkg::PI_Q16) || t_ff[bps_pkg::T_W-1];

   // flight time sign and saturation
   assign t_neg = horiz_ff[bps_pkg::H_W-1] ^ vx_ff[bps_pkg::V_W-1];
   assign t_mag = (dq_ff > bps_pkg::T_MAX) ? bps_pkg::T_MAX : dq_ff;
   assign t_in  = t_neg ? -bps_pkg::T_W'(t_mag) : bps_pkg::T_W'(t_mag);

   // next compensation angle
   assign step_val = bps_pkg::ANG_W'(dq_ff[bps_pkg::STEP_W-1:0]);
   assign comp_in  = dir_ff ? comp_ff + step_val : comp_ff - step_val;

   // height error
   assign err_in = bps_pkg::ERR_W'(hh_ff) - vyt_ff - bps_pkg::ERR_W'(prod_ff >>> 17);

   // rounded and clamped degrees
   assign deg_full = (prod_ff + bps_pkg::DEG_ROUND) >>> 16;
   always_comb begin
      priority if (deg_full > bps_pkg::DEG_MAX) begin
         deg_sat = bps_pkg::DEG_W'(bps_pkg::DEG_MAX);
      end else if (deg_full < -bps_pkg::DEG_MAX) begin
         deg_sat = bps_pkg::DEG_W'(-bps_pkg::DEG_MAX);
      end else begin
         deg_sat = bps_pkg::DEG_W'(deg_full);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // cordic and divider launch
   always_comb begin
      creq.start = 1'b0;
      creq.angle = comp_in + bps_pkg::ANG_W'(ap_ff);
      div_start  = 1'b0;
      div_num    = bps_pkg::DEG1_X256 + bps_pkg::DIVN_W'(div_ff >> 1);
      div_den    = bps_pkg::DIVD_W'(div_ff);
      if (state_ff == S_IDLE) begin
         creq.start = req_chan.valid;
         creq.angle = bps_pkg::ANG_W'(req_chan.sight_angle);
      end else if (state_ff == S_SDIV) begin
         creq.start = div_done;
      end
      if (state_ff == S_STEP) begin
         div_start = 1'b1;
      end else if (state_ff == S_VY && vx_ff != '0) begin
         div_start = 1'b1;
         div_num   = bps_pkg::DIVN_W'({horiz_mag, 16'b0});
         div_den   = vx_mag;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_chan.valid) state_in = S_CS0;
         S_CS0:  if (crsp.done) state_in = S_H1;
         S_H1:   state_in = S_HZ;
         S_HZ:   state_in = S_HR;
         S_HR:   state_in = S_HS;
         S_HS:   state_in = S_STEP;
         S_STEP: state_in = S_SDIV;
         S_SDIV: if (div_done) state_in = S_CF;
         S_CF:   if (crsp.done) state_in = S_VX;
         S_VX:   state_in = S_VY;
         S_VY:   state_in = (vx_ff == '0) ? S_RND : S_TDIV;
         S_TDIV: if (div_done) state_in = S_T1;
         S_T1:   state_in = S_T2;
         S_T2:   state_in = S_T3;
         S_T3:   state_in = S_ERR;
         S_ERR:  state_in = S_EVAL;
         S_EVAL: begin
            priority if (overrun) begin
               state_in = S_DEG;
            end else if (geom_bad) begin
               state_in = S_RND;
            end else if (err_mag < bps_pkg::ERR_W'(tol_ff)) begin
               state_in = S_DEG;
            end else if (cnt_inc >= bps_pkg::STEP_CNT_W'(bps_pkg::MAX_SEARCH_STEPS)) begin
               state_in = S_DEG;
            end else begin
               state_in = S_STEP;
            end
         end
         S_DEG:  state_in = S_RND;
         S_RND:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         if (state_ff == S_RND && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      drem_ff <= drem_in;
      dden_ff <= dden_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      unique case (state_ff)
         S_IDLE: begin
            ap_ff     <= req_chan.sight_angle;
            dist_ff   <= req_chan.target_distance;
            spd_ff    <= req_chan.muzzle_speed;
            comp_ff   <= '0;
            prev_ff   <= '0;
            div_ff    <= bps_pkg::DIV_START;
            dir_ff    <= 1'b1;
            cnt_ff    <= '0;
            status_ff <= bps_pkg::STAT_CONVERGED;
         end
         S_CS0: begin
            sp_ff <= crsp.sin;
            cp_ff <= crsp.cos;
         end
         S_HZ: h1_ff    <= bps_pkg::H_W'(prod_ff >>> 16);
         S_HR: horiz_ff <= bps_pkg::H_W'(prod_ff >>> 16);
         S_HS: hr_ff    <= h1_ff + bps_pkg::H_W'(prod_ff >>> 16);
         S_SDIV: begin
            if (div_done) begin
               comp_ff <= comp_in;
               af_ff   <= creq.angle;
            end
         end
         S_CF: cf_ff <= crsp.cos;
         S_VX: vx_ff <= bps_pkg::V_W'(prod_ff >>> 16);
         S_VY: begin
            vy_ff <= bps_pkg::V_W'(prod_ff >>> 16);
            if (vx_ff == '0) begin
               status_ff <= bps_pkg::STAT_GEOMETRY;
            end
         end
         S_TDIV: begin
            hh_ff <= hr_ff - bps_pkg::H_W'(prod_ff >>> 16);
            if (div_done) begin
               t_ff <= t_in;
            end
         end
         S_T2:  vyt_ff <= bps_pkg::ERR_W'(prod_ff >>> 16);
         S_ERR: err_ff <= err_in;
         S_EVAL: begin
            prev_ff <= err_ff;
            if (reverse) begin
               dir_ff <= !dir_ff;
               div_ff <= div_inc;
            end
            priority if (overrun) begin
               status_ff <= bps_pkg::STAT_OVERRUN;
            end else if (geom_bad) begin
               status_ff <= bps_pkg::STAT_GEOMETRY;
            end else begin
               cnt_ff <= cnt_inc;
               if (err_mag < bps_pkg::ERR_W'(tol_ff)) begin
                  status_ff <= bps_pkg::STAT_CONVERGED;
               end else begin
                  status_ff <= bps_pkg::STAT_OVERRUN;
               end
            end
         end
         S_RND: begin
            if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_deg_ff    <= (status_ff == bps_pkg::STAT_GEOMETRY) ? '0 : deg_sat;
            end
         end
         default: ;
      endcase
   end

   // channel outputs
   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.compensation_deg = rsp_deg_ff;
   assign rsp_chan.solve_status     = rsp_status_ff;

   // cordic only finishes while the sequencer waits for it
   a_cordic_wait: assert property (@(posedge clock) disable iff (reset)
      crsp.done |-> (state_ff == S_CS0 || state_ff == S_CF))
      else $error("cordic result with no waiting state");

   // divider is idle whenever a new division is launched
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_done)
      else $error("divider launched while busy");

   // step count stays within the cap
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bps_pkg::STEP_CNT_W'(bps_pkg::MAX_SEARCH_STEPS))
      else $error("search step count beyond cap");

   // geometry failures report a zero angle
   a_geom_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bps_pkg::STAT_GEOMETRY) |-> (rsp_deg_ff == '0))
      else $error("geometry error with nonzero angle");

endmodule

// File: tb/bps_tb_if_note.sv
`timescale 1ns / 1ps
// shared stimulus record types for the pitch solver testbench
package bps_tb_pkg;
   import bps_pkg::*;

   // one directed request, with an optional typed-in result
   typedef struct {
      logic [SIGHT_W-1:0]        sight;
      logic [DIST_W-1:0]         distance;
      logic [SPEED_W-1:0]        speed;
      bit                        fixed_result;
      logic signed [DEG_W-1:0]   deg;
      logic [STATUS_W-1:0]       status;
   } aim_row_t;

   // one awaited result item
   typedef struct {
      logic signed [DEG_W-1:0]   deg;
      logic [STATUS_W-1:0]       status;
   } aim_result_t;
endpackage

// File: tb/tb_ballistic_pitch_solver_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the pitch solver top level
module tb_ballistic_pitch_solver_top;
   import bps_pkg::*;
   import bps_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bps_req_if req_chan ();
   bps_rsp_if rsp_chan ();
   bps_csr_if csr_chan ();

   ballistic_pitch_solver_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // register shadows
   logic [RADIUS_W-1:0] sh_radius;
   logic [GRAV_W-1:0]   sh_gravity;
   logic [TOL_W-1:0]    sh_tolerance;
   logic [LIMIT_W-1:0]  sh_limit;

   aim_result_t pending_aims[$];
   int  mismatches;
   int  results_seen;
   int  items_sent;
   int  stat_hits[3];
   bit  quiet_tail;
   int  idle_cycles;

   // arctangent of 2^-i, Q30
   localparam longint ATAN_TAB[18] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384, 8192 };

   // cordic sine and cosine of a Q16 angle, results Q16
   function automatic void trig_q16(input longint ang, output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = (ang * 16384) % 64'sd6746518852;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z = 64'sd3373259426 - z;
         flip = 1;
      end else if (z < -64'sd1686629713) begin
         z = -64'sd3373259426 - z;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ATAN_TAB[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_TAB[i];
         end
         x = nx;
      end
      s = (y + 8192) >>> 14;
      c = (x + 8192) >>> 14;
      if (flip) c = -c;
   endfunction

   // launch angle search for one request
   function automatic aim_result_t solve_pitch(input logic [SIGHT_W-1:0] sight,
                                               input logic [DIST_W-1:0] dist_in,
                                               input logic [SPEED_W-1:0] speed_in);
      aim_result_t res;
      longint ap, distance, spd, r, sp, cp, sf, cf, h1, horiz, af, vx, vy, t, h, calh;
      longint err, last, deg, angle, prev_err, stp;
      longint unsigned divisor;
      bit     upward;
      int     steps;
      logic [STATUS_W-1:0] st;
      ap = sight; distance = dist_in; spd = speed_in; r = sh_radius;
      angle = 0; prev_err = 0; divisor = DIV_START; upward = 1; steps = 0;
      trig_q16(ap, sp, cp);
      h1 = (distance * cp) >>> 16;
      horiz = (sp * distance) >>> 16;
      forever begin
         stp = (292864 + divisor / 2) / divisor;
         angle += upward ? stp : -stp;
         af = angle + ap;
         trig_q16(af, sf, cf);
         vx = (spd * sf) >>> 16;
         vy = (spd * cf) >>> 16;
         if (vx == 0) begin
            st = STAT_GEOMETRY;
            break;
         end
         t = (horiz * 65536) / vx;
         if (t > 16777215) t = 16777215;
         if (t < -16777215) t = -16777215;
         h = h1 + ((r * cp) >>> 16) - ((r * cf) >>> 16);
         calh = ((vy * t) >>> 16) + (((longint'(sh_gravity) * ((t * t) >>> 16)) >>> 16) >>> 1);
         err = h - calh;
         if (err > 64'sd549755813887) err = 64'sd549755813887;
         if (err < -64'sd549755813887) err = -64'sd549755813887;
         last = prev_err;
         prev_err = err;
         // error grew: turn around with a finer step
         if (last != 0 && (err < 0 ? -err : err) > (last < 0 ? -last : last)) begin
            upward = !upward;
            divisor += DIV_INC;
            if (divisor > longint'(sh_limit) * 256) begin
               st = STAT_OVERRUN;
               break;
            end
         end
         if (horiz < 0 || vx < 0 || af > 205887 || t < 0) begin
            st = STAT_GEOMETRY;
            break;
         end
         steps++;
         if ((err < 0 ? -err : err) < longint'(sh_tolerance)) begin
            st = STAT_CONVERGED;
            break;
         end
         if (steps >= MAX_SEARCH_STEPS) begin
            st = STAT_OVERRUN;
            break;
         end
      end
      if (st == STAT_GEOMETRY) deg = 0;
      else begin
         deg = (angle * 3754936 + 32768) >>> 16;
         if (deg > 11796480) deg = 11796480;
         if (deg < -11796480) deg = -11796480;
      end
      res.deg = deg[DEG_W-1:0];
      res.status = st;
      return res;
   endfunction

   // directed requests: extremes, each status, the named special cases
   aim_row_t aim_table[] = '{
      '{18'd0,      21'd0,       21'd0,       1, 25'sd0, STAT_GEOMETRY},
      '{18'd102943, 21'd327680,  21'd0,       1, 25'sd0, STAT_GEOMETRY},
      '{18'd205887, 21'd655360,  21'd983040,  1, 25'sd0, STAT_GEOMETRY},
      '{18'd262143, 21'd2097151, 21'd2097151, 0, 25'sd0, STAT_CONVERGED},
      '{18'd0,      21'd655360,  21'd983040,  0, 25'sd0, STAT_CONVERGED},
      '{18'd102943, 21'd327680,  21'd1310720, 0, 25'sd0, STAT_CONVERGED},
      '{18'd102943, 21'd1966080, 21'd1966080, 0, 25'sd0, STAT_CONVERGED},
      '{18'd90000,  21'd655360,  21'd1966080, 0, 25'sd0, STAT_CONVERGED},
      '{18'd120000, 21'd1310720, 21'd1638400, 0, 25'sd0, STAT_CONVERGED},
      '{18'd102943, 21'd1966080, 21'd327680,  0, 25'sd0, STAT_CONVERGED},
      '{18'd102943, 21'd0,       21'd1966080, 0, 25'sd0, STAT_CONVERGED},
      '{18'd150000, 21'd983040,  21'd655360,  0, 25'sd0, STAT_CONVERGED},
      '{18'd60000,  21'd983040,  21'd1310720, 0, 25'sd0, STAT_CONVERGED},
      '{18'd1,      21'd1,       21'd1,       0, 25'sd0, STAT_CONVERGED},
      '{18'd131071, 21'd1048575, 21'd1048575, 0, 25'sd0, STAT_CONVERGED},
      '{18'd205886, 21'd65536,   21'd1966080, 0, 25'sd0, STAT_CONVERGED}
   };

   // result side: random stall bursts
   int rsp_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (quiet_tail) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(0, 5);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // result check against the oldest awaited item
   always @(posedge clock) begin
      aim_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_aims.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: deg=%0d status=%0d",
                        rsp_chan.compensation_deg, rsp_chan.solve_status);
         end else begin
            want = pending_aims.pop_front();
            if (want.deg !== rsp_chan.compensation_deg ||
                want.status !== rsp_chan.solve_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected deg=%0d status=%0d, got deg=%0d status=%0d",
                           want.deg, want.status, rsp_chan.compensation_deg,
                           rsp_chan.solve_status);
            end
            if (want.status < 3) stat_hits[want.status]++;
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ballistic_pitch_solver_top");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_LAUNCHER_RADIUS:  sh_radius    = val[RADIUS_W-1:0];
         REG_GRAVITY_ACCEL:    sh_gravity   = val[GRAV_W-1:0];
         REG_HEIGHT_TOLERANCE: sh_tolerance = val[TOL_W-1:0];
         default:              sh_limit     = val[LIMIT_W-1:0];
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] rad, input logic [CSR_DATA_W-1:0] grav,
                           input logic [CSR_DATA_W-1:0] tol, input logic [CSR_DATA_W-1:0] lim);
      // only between phases, with nothing in flight
      req_chan.valid <= 1'b0;
      while (pending_aims.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_reg(REG_LAUNCHER_RADIUS, rad);
      write_reg(REG_GRAVITY_ACCEL, grav);
      write_reg(REG_HEIGHT_TOLERANCE, tol);
      write_reg(REG_PRECISION_LIMIT, lim);
   endtask

   // present one request, optionally after a gap, and log what it must yield
   task automatic send_aim(input logic [SIGHT_W-1:0] sight, input logic [DIST_W-1:0] distance,
                           input logic [SPEED_W-1:0] speed, input bit fixed,
                           input aim_result_t fixed_res);
      int gap;
      gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sight_angle <= sight;
      req_chan.target_distance <= distance;
      req_chan.muzzle_speed <= speed;
      do @(posedge clock); while (!req_chan.ready);
      pending_aims.push_back(fixed ? fixed_res : solve_pitch(sight, distance, speed));
      items_sent++;
   endtask

   // mostly plausible shots, some full-range noise and edge values
   task automatic send_random_aim();
      logic [SIGHT_W-1:0] s;
      logic [DIST_W-1:0]  d;
      logic [SPEED_W-1:0] v;
      aim_result_t none;
      int pick;
      none = '{default: '0};
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         s = SIGHT_W'($urandom_range(70000, 140000));
         d = DIST_W'($urandom_range(65536, 1966080));
         v = SPEED_W'($urandom_range(327680, 1966080));
      end else if (pick < 85) begin
         s = SIGHT_W'($urandom());
         d = DIST_W'($urandom());
         v = SPEED_W'($urandom());
      end else begin
         s = SIGHT_W'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? 18'd205887 : 18'd0)
                                           : $urandom());
         d = DIST_W'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? 21'd1966080 : 21'd0)
                                          : $urandom());
         v = SPEED_W'($urandom_range(0, 1) ? ($urandom_range(0, 1) ? 21'd1966080 : 21'd0)
                                           : $urandom());
      end
      send_aim(s, d, v, 0, none);
   endtask

   initial begin
      aim_result_t typed;
      req_chan.valid = 1'b0;
      req_chan.sight_angle = '0;
      req_chan.target_distance = '0;
      req_chan.muzzle_speed = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.wdata = '0;
      rsp_chan.ready = 1'b0;
      sh_radius = RADIUS_RESET;
      sh_gravity = GRAV_RESET;
      sh_tolerance = TOL_RESET;
      sh_limit = LIMIT_RESET;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      stat_hits = '{0, 0, 0};
      quiet_tail = 0;
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset register values
      foreach (aim_table[i]) begin
         typed.deg = aim_table[i].deg;
         typed.status = aim_table[i].status;
         send_aim(aim_table[i].sight, aim_table[i].distance, aim_table[i].speed,
                  aim_table[i].fixed_result, typed);
      end

      // zero radius, strongest gravity, loose tolerance, widest limit
      set_regs(20'd0, 20'd1048575, 20'd65535, 20'd63);
      repeat (30) send_random_aim();

      // widest radius, no gravity, zero tolerance, first reversal overruns
      set_regs(20'd65535, 20'd0, 20'd0, 20'd1);
      repeat (10) send_random_aim();

      // random settings
      set_regs(CSR_DATA_W'($urandom_range(0, 65535)), CSR_DATA_W'($urandom_range(300000, 900000)),
               CSR_DATA_W'($urandom_range(200, 20000)), CSR_DATA_W'($urandom_range(2, 40)));
      repeat (30) send_random_aim();

      // back to reset values, quiet tail at the end
      set_regs(RADIUS_RESET, GRAV_RESET, TOL_RESET, LIMIT_RESET);
      for (int n = 0; n < 60; n++) begin
         if (n == 40) quiet_tail = 1;
         send_random_aim();
      end
      req_chan.valid <= 1'b0;

      while (pending_aims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests over three register settings plus reset values",
               items_sent);
      $display("statuses seen: converged %0d, overrun %0d, geometry %0d; mismatches %0d",
               stat_hits[0], stat_hits[1], stat_hits[2], mismatches);
      if (mismatches == 0 && pending_aims.size() == 0)
         $display("PASS ballistic_pitch_solver_top");
      else
         $display("FAIL ballistic_pitch_solver_top");
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_if.sv
hw/rtl/bps_cordic.sv
hw/rtl/ballistic_pitch_solver_top.sv
tb/bps_tb_if_note.sv
tb/tb_ballistic_pitch_solver_top.sv
